### design/rmp_pkg.sv
// Region mosaic pixelation: shared types and constants.
// Used by the modules of the block other than the RAM, and by the channel interfaces.
package rmp_pkg;

	localparam int COLOR_W    = 24;
	localparam int CHAN_W     = 8;
	localparam int SIDE_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = 2;

	localparam logic [11:0] RST_FRAME_WIDTH  = 12'd1280;
	localparam logic [11:0] RST_FRAME_HEIGHT = 12'd720;
	localparam logic [7:0]  RST_MOSAIC_BLOCK = 8'd20;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH   = 3'd0,
		REG_FRAME_HEIGHT  = 3'd1,
		REG_REGION_LEFT   = 3'd2,
		REG_REGION_TOP    = 3'd3,
		REG_REGION_WIDTH  = 3'd4,
		REG_REGION_HEIGHT = 3'd5,
		REG_MOSAIC_BLOCK  = 3'd6,
		REG_MOSAIC_ENABLE = 3'd7
	} rmp_reg_t;

	typedef struct packed {
		logic [11:0] frame_width;
		logic [11:0] frame_height;
		logic [10:0] region_left;
		logic [10:0] region_top;
		logic [11:0] region_width;
		logic [11:0] region_height;
		logic [7:0]  mosaic_block;
		logic        mosaic_enable;
	} rmp_cfg_t;

	// Per-item control from front to back
	typedef struct packed {
		logic masked;
		logic store;
	} rmp_ctl_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_LOAD,
		DIV_RUN
	} rmp_div_state_t;

endpackage

### design/rmp_stream_if.sv
// Region mosaic pixelation: valid/ready channel interfaces for pixels in,
// pixels out and configuration writes. Depends on rmp_pkg.
interface rmp_pix_in_if;
	logic                       valid;
	logic                       ready;
	logic                       start_of_frame;
	logic [rmp_pkg::CHAN_W-1:0] red_in;
	logic [rmp_pkg::CHAN_W-1:0] green_in;
	logic [rmp_pkg::CHAN_W-1:0] blue_in;

	modport source (output valid, start_of_frame, red_in, green_in, blue_in, input ready);
	modport sink (input valid, start_of_frame, red_in, green_in, blue_in, output ready);
endinterface

interface rmp_pix_out_if;
	logic                       valid;
	logic                       ready;
	logic [rmp_pkg::CHAN_W-1:0] red_out;
	logic [rmp_pkg::CHAN_W-1:0] green_out;
	logic [rmp_pkg::CHAN_W-1:0] blue_out;
	logic                       was_masked;

	modport source (output valid, red_out, green_out, blue_out, was_masked, input ready);
	modport sink (input valid, red_out, green_out, blue_out, was_masked, output ready);
endinterface

interface rmp_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [rmp_pkg::CFG_IDX_W-1:0]  index;
	logic [rmp_pkg::CFG_DATA_W-1:0] wdata;

	modport source (output valid, index, wdata, input ready);
	modport sink (input valid, index, wdata, output ready);
endinterface

### design/region_mosaic_pixelate_unit.sv
// Region mosaic pixelation unit: accepts one RGB pixel per clock in raster order and returns
// one pixel per clock while no output stall or divider rebuild holds the flow; a four-entry
// queue between the position/classification front end and the RAM back end absorbs output
// stalls. Inside the programmed rectangle each pixel takes the color of its block's top-left
// pixel, held in a one-port-write, one-port-read RAM with one entry per block column. A
// configuration write drops pix_in.ready while a shift-subtract divider rebuilds the block
// offsets of the current raster position; configuration must be written only while idle,
// and the block itself does not enforce it.
module region_mosaic_pixelate_unit #(
	parameter int MAX_FRAME_WIDTH  = 2048,
	parameter int MAX_FRAME_HEIGHT = 2048,
	parameter int MAX_BLOCK_SIDE   = 255
) (
	input  logic               clk,
	input  logic               arst_n,
	rmp_pix_in_if.sink         pix_in,
	rmp_pix_out_if.source      pix_out,
	rmp_cfg_if.sink            cfg
);

	localparam int XW = $clog2(MAX_FRAME_WIDTH);
	localparam int QW = rmp_pkg::COLOR_W + $bits(rmp_pkg::rmp_ctl_t) + XW;

	rmp_pkg::rmp_cfg_t           cfg_q;
	logic                        cfg_wr;
	logic                        push, pop, q_full, q_empty;
	logic [rmp_pkg::COLOR_W-1:0] push_color, pop_color, out_color;
	rmp_pkg::rmp_ctl_t           push_ctl, pop_ctl;
	logic [XW-1:0]               push_idx, pop_idx;
	logic [QW-1:0]               push_data, pop_data;

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width   <= rmp_pkg::RST_FRAME_WIDTH;
			cfg_q.frame_height  <= rmp_pkg::RST_FRAME_HEIGHT;
			cfg_q.region_left   <= '0;
			cfg_q.region_top    <= '0;
			cfg_q.region_width  <= '0;
			cfg_q.region_height <= '0;
			cfg_q.mosaic_block  <= rmp_pkg::RST_MOSAIC_BLOCK;
			cfg_q.mosaic_enable <= 1'b0;
		end else if (cfg_wr) begin
			case (rmp_pkg::rmp_reg_t'(cfg.index))
				rmp_pkg::REG_FRAME_WIDTH:   cfg_q.frame_width   <= cfg.wdata;
				rmp_pkg::REG_FRAME_HEIGHT:  cfg_q.frame_height  <= cfg.wdata;
				rmp_pkg::REG_REGION_LEFT:   cfg_q.region_left   <= cfg.wdata[10:0];
				rmp_pkg::REG_REGION_TOP:    cfg_q.region_top    <= cfg.wdata[10:0];
				rmp_pkg::REG_REGION_WIDTH:  cfg_q.region_width  <= cfg.wdata;
				rmp_pkg::REG_REGION_HEIGHT: cfg_q.region_height <= cfg.wdata;
				rmp_pkg::REG_MOSAIC_BLOCK:  cfg_q.mosaic_block  <= cfg.wdata[7:0];
				rmp_pkg::REG_MOSAIC_ENABLE: cfg_q.mosaic_enable <= cfg.wdata[0];
				default: ;
			endcase
		end
	end

	rmp_front #(
		.MAX_FRAME_WIDTH  (MAX_FRAME_WIDTH),
		.MAX_FRAME_HEIGHT (MAX_FRAME_HEIGHT),
		.MAX_BLOCK_SIDE   (MAX_BLOCK_SIDE)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.cfg_wr     (cfg_wr),
		.in_valid   (pix_in.valid),
		.in_ready   (pix_in.ready),
		.sof        (pix_in.start_of_frame),
		.in_color   ({pix_in.red_in, pix_in.green_in, pix_in.blue_in}),
		.q_full     (q_full),
		.push       (push),
		.push_color (push_color),
		.push_ctl   (push_ctl),
		.push_idx   (push_idx)
	);

	assign push_data = {push_color, push_ctl, push_idx};

	rmp_queue #(
		.DATA_W (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	assign pop_color = pop_data[QW-1 -: rmp_pkg::COLOR_W];
	assign pop_ctl   = pop_data[XW +: $bits(rmp_pkg::rmp_ctl_t)];
	assign pop_idx   = pop_data[XW-1:0];

	rmp_back #(
		.MAX_FRAME_WIDTH (MAX_FRAME_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.pop        (pop),
		.pop_color  (pop_color),
		.pop_ctl    (pop_ctl),
		.pop_idx    (pop_idx),
		.out_valid  (pix_out.valid),
		.out_ready  (pix_out.ready),
		.out_color  (out_color),
		.out_masked (pix_out.was_masked)
	);

	assign pix_out.red_out   = out_color[23:16];
	assign pix_out.green_out = out_color[15:8];
	assign pix_out.blue_out  = out_color[7:0];

endmodule

### design/rmp_ram.sv
// Region mosaic pixelation: generic simple dual-port RAM, one write and
// one registered read per cycle. No dependencies.
module rmp_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### design/rmp_front.sv
// Region mosaic pixelation front end: tracks raster position and block
// offsets, classifies each pixel and pushes it to the queue. Depends on rmp_pkg.
module rmp_front #(
	parameter int MAX_FRAME_WIDTH  = 2048,
	parameter int MAX_FRAME_HEIGHT = 2048,
	parameter int MAX_BLOCK_SIDE   = 255
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  rmp_pkg::rmp_cfg_t                     cfg,
	input  logic                                  cfg_wr,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  sof,
	input  logic [rmp_pkg::COLOR_W-1:0]           in_color,
	input  logic                                  q_full,
	output logic                                  push,
	output logic [rmp_pkg::COLOR_W-1:0]           push_color,
	output rmp_pkg::rmp_ctl_t                     push_ctl,
	output logic [$clog2(MAX_FRAME_WIDTH)-1:0]    push_idx
);

	localparam int XW = $clog2(MAX_FRAME_WIDTH);
	localparam int YW = $clog2(MAX_FRAME_HEIGHT);
	localparam int DW = (XW > YW) ? XW : YW;
	localparam int EW = ((DW > 12) ? DW : 12) + 1;
	localparam int CW = $clog2(DW + 1);
	localparam int SW = rmp_pkg::SIDE_W;

	rmp_pkg::rmp_div_state_t state_q, state_nx;

	logic [XW-1:0] col_q, cur_col, col_nx, bx_q, cur_bx, bx_nx;
	logic [YW-1:0] line_q, cur_line, line_nx;
	logic [SW-1:0] ax_q, cur_ax, ax_nx, ay_q, cur_ay, ay_nx;
	logic [SW-1:0] side;
	logic [EW-1:0] w_eff, h_eff, fw_e, fh_e;
	logic [EW-1:0] left_e, top_e, rgt_e, bot_e;
	logic [EW-1:0] cur_col_e, cur_line_e, col_inc_e, line_inc_e, col_nx_e, line_nx_e;
	logic          wrap, fits, in_x, in_y, in_rect, store, busy, div_done;

	logic [DW-1:0] dvd_x_q, dvd_y_q, dx_init, dy_init;
	logic [SW-1:0] rem_x_q, rem_y_q, rx_nx, ry_nx;
	logic [SW:0]   tx, ty;
	logic          gx, gy;
	logic [CW-1:0] cnt_q;

	// Effective frame size and block side
	always_comb begin
		fw_e = EW'(cfg.frame_width);
		fh_e = EW'(cfg.frame_height);
		if (cfg.frame_width == '0) begin
			w_eff = EW'(1);
		end else if (fw_e > EW'(MAX_FRAME_WIDTH)) begin
			w_eff = EW'(MAX_FRAME_WIDTH);
		end else begin
			w_eff = fw_e;
		end
		if (cfg.frame_height == '0) begin
			h_eff = EW'(1);
		end else if (fh_e > EW'(MAX_FRAME_HEIGHT)) begin
			h_eff = EW'(MAX_FRAME_HEIGHT);
		end else begin
			h_eff = fh_e;
		end
		if (int'(cfg.mosaic_block) > MAX_BLOCK_SIDE) begin
			side = SW'(MAX_BLOCK_SIDE);
		end else begin
			side = cfg.mosaic_block;
		end
	end

	// Classify the pixel and work out the next position
	always_comb begin
		cur_col  = sof ? '0 : col_q;
		cur_line = sof ? '0 : line_q;
		cur_ax   = sof ? '0 : ax_q;
		cur_bx   = sof ? '0 : bx_q;
		cur_ay   = sof ? '0 : ay_q;

		cur_col_e  = EW'(cur_col);
		cur_line_e = EW'(cur_line);
		left_e     = EW'(cfg.region_left);
		top_e      = EW'(cfg.region_top);
		rgt_e      = left_e + EW'(cfg.region_width);
		bot_e      = top_e + EW'(cfg.region_height);

		fits    = (rgt_e <= w_eff) && (bot_e <= h_eff);
		in_x    = (cur_col_e >= left_e) && (cur_col_e < rgt_e);
		in_y    = (cur_line_e >= top_e) && (cur_line_e < bot_e);
		in_rect = cfg.mosaic_enable && (side != '0) && fits && in_x && in_y;
		store   = in_rect && (cur_ax == '0) && (cur_ay == '0);

		col_inc_e  = cur_col_e + EW'(1);
		wrap       = col_inc_e >= w_eff;
		col_nx     = wrap ? '0 : XW'(col_inc_e);
		line_inc_e = wrap ? (cur_line_e + EW'(1)) : cur_line_e;
		line_nx    = (line_inc_e >= h_eff) ? '0 : YW'(line_inc_e);
		col_nx_e   = EW'(col_nx);
		line_nx_e  = EW'(line_nx);

		// Offsets restart at column 0 and where the rectangle starts; advance from its left edge on
		if ((col_nx_e == left_e) || (col_nx == '0)) begin
			ax_nx = '0;
			bx_nx = '0;
		end else if (cur_col_e >= left_e) begin
			if (({1'b0, cur_ax} + 9'd1) == {1'b0, side}) begin
				ax_nx = '0;
				bx_nx = cur_bx + XW'(1);
			end else begin
				ax_nx = cur_ax + SW'(1);
				bx_nx = cur_bx;
			end
		end else begin
			ax_nx = cur_ax;
			bx_nx = cur_bx;
		end

		if ((line_nx_e == top_e) || (line_nx == '0)) begin
			ay_nx = '0;
		end else if ((line_nx != cur_line) && (cur_line_e >= top_e)) begin
			if (({1'b0, cur_ay} + 9'd1) == {1'b0, side}) begin
				ay_nx = '0;
			end else begin
				ay_nx = cur_ay + SW'(1);
			end
		end else begin
			ay_nx = cur_ay;
		end
	end

	assign busy       = state_q != rmp_pkg::DIV_IDLE;
	assign in_ready   = !busy && !q_full;
	assign push       = in_valid && in_ready;
	assign push_color = in_color;
	assign push_ctl   = '{masked: in_rect, store: store};
	assign push_idx   = cur_bx;

	// Divider state: after a register write, rebuild offsets for the current position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rmp_pkg::DIV_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign div_done = cnt_q == CW'(DW);

	always_comb begin
		state_nx = state_q;
		case (state_q)
			rmp_pkg::DIV_IDLE: begin
				if (cfg_wr) state_nx = rmp_pkg::DIV_LOAD;
			end
			rmp_pkg::DIV_LOAD: begin
				state_nx = cfg_wr ? rmp_pkg::DIV_LOAD : rmp_pkg::DIV_RUN;
			end
			rmp_pkg::DIV_RUN: begin
				if (cfg_wr) begin
					state_nx = rmp_pkg::DIV_LOAD;
				end else if (div_done) begin
					state_nx = rmp_pkg::DIV_IDLE;
				end
			end
			default: state_nx = rmp_pkg::DIV_IDLE;
		endcase
	end

	// Shift-subtract step, one quotient bit per cycle for both axes
	always_comb begin
		dx_init = (EW'(col_q) >= left_e) ? DW'(EW'(col_q) - left_e) : '0;
		dy_init = (EW'(line_q) >= top_e) ? DW'(EW'(line_q) - top_e) : '0;
		tx = {rem_x_q, dvd_x_q[DW-1]};
		ty = {rem_y_q, dvd_y_q[DW-1]};
		gx = tx >= {1'b0, side};
		gy = ty >= {1'b0, side};
		rx_nx = gx ? SW'(tx - {1'b0, side}) : SW'(tx);
		ry_nx = gy ? SW'(ty - {1'b0, side}) : SW'(ty);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == rmp_pkg::DIV_LOAD) begin
			cnt_q <= '0;
		end else if ((state_q == rmp_pkg::DIV_RUN) && !div_done) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rmp_pkg::DIV_LOAD) begin
			dvd_x_q <= dx_init;
			dvd_y_q <= dy_init;
			rem_x_q <= '0;
			rem_y_q <= '0;
		end else if ((state_q == rmp_pkg::DIV_RUN) && !div_done) begin
			dvd_x_q <= {dvd_x_q[DW-2:0], gx};
			dvd_y_q <= {dvd_y_q[DW-2:0], gy};
			rem_x_q <= rx_nx;
			rem_y_q <= ry_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			line_q <= '0;
			ax_q   <= '0;
			bx_q   <= '0;
			ay_q   <= '0;
		end else if (push) begin
			col_q  <= col_nx;
			line_q <= line_nx;
			ax_q   <= ax_nx;
			bx_q   <= bx_nx;
			ay_q   <= ay_nx;
		end else if ((state_q == rmp_pkg::DIV_RUN) && div_done && !cfg_wr) begin
			ax_q <= rem_x_q;
			bx_q <= XW'(dvd_x_q);
			ay_q <= rem_y_q;
		end
	end

	a_ax_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && (side != '0)) |-> (ax_q < side))
		else $error("across offset outside block");

	a_ay_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && (side != '0)) |-> (ay_q < side))
		else $error("down offset outside block");

endmodule

### design/rmp_queue.sv
// Region mosaic pixelation: short register queue between front and back.
// Depends on rmp_pkg for its depth.
module rmp_queue #(
	parameter int DATA_W = 38
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              full,
	input  logic              pop,
	output logic [DATA_W-1:0] pop_data,
	output logic              empty
);

	localparam int PW = rmp_pkg::QUEUE_PTR_W;

	logic [DATA_W-1:0] mem_q [rmp_pkg::QUEUE_DEPTH];
	logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [PW:0]       count_q;

	assign full     = count_q == (PW + 1)'(rmp_pkg::QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PW'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + PW'(1);
			if (push && !pop) begin
				count_q <= count_q + (PW + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PW + 1)'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue pop while empty");

endmodule

### design/rmp_back.sv
// Region mosaic pixelation back end: stores and fetches block colors in the
// block-column RAM and drives the output register. Depends on rmp_pkg, rmp_ram.
module rmp_back #(
	parameter int MAX_FRAME_WIDTH = 2048
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               q_empty,
	output logic                               pop,
	input  logic [rmp_pkg::COLOR_W-1:0]        pop_color,
	input  rmp_pkg::rmp_ctl_t                  pop_ctl,
	input  logic [$clog2(MAX_FRAME_WIDTH)-1:0] pop_idx,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [rmp_pkg::COLOR_W-1:0]        out_color,
	output logic                               out_masked
);

	logic                        s1_v_q, s1_adv, out_v_q;
	logic [rmp_pkg::COLOR_W-1:0] color_s1, rdata, color_q;
	logic                        masked_s1, from_ram_s1, masked_q;
	logic                        ram_we, ram_re;

	assign s1_adv = s1_v_q && (!out_v_q || out_ready);
	assign pop    = !q_empty && (!s1_v_q || s1_adv);
	assign ram_we = pop && pop_ctl.masked && pop_ctl.store;
	assign ram_re = pop && pop_ctl.masked && !pop_ctl.store;

	// Read data holds while s1 stalls since no new read is issued then
	rmp_ram #(
		.WIDTH (rmp_pkg::COLOR_W),
		.DEPTH (MAX_FRAME_WIDTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pop_idx),
		.wdata (pop_color),
		.re    (ram_re),
		.raddr (pop_idx),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (pop) begin
				s1_v_q <= 1'b1;
			end else if (s1_adv) begin
				s1_v_q <= 1'b0;
			end
			if (s1_adv) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			color_s1    <= pop_color;
			masked_s1   <= pop_ctl.masked;
			from_ram_s1 <= pop_ctl.masked && !pop_ctl.store;
		end
		if (s1_adv) begin
			color_q  <= from_ram_s1 ? rdata : color_s1;
			masked_q <= masked_s1;
		end
	end

	assign out_valid  = out_v_q;
	assign out_color  = color_q;
	assign out_masked = masked_q;

endmodule
